// File: hdl/b62c_pkg.sv
// b62c_pkg: types, constants and helper functions shared by the base62 codec
// depends on nothing; imported by b62c_front, b62c_back and base62_codec_unit
`timescale 1ns / 1ps

package b62c_pkg;

    localparam int FIELD_W         = 64;
    localparam int CHAR_W          = 8;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int DIGIT_W         = 6;
    localparam int MAX_DIGITS      = 11;
    localparam int CNT_W           = 4;
    localparam int CMD_DEPTH       = 2;
    localparam int RES_DEPTH       = 2;

    // divide-by-62 step: remainder and one 16-bit chunk, quotient by reciprocal
    localparam int CHUNK_W     = 16;
    localparam int STEP_X_W    = DIGIT_W + CHUNK_W;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = STEP_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_62 = 23'd4329605;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;

    typedef struct packed {
        logic                 dec;
        logic [FIELD_W-1:0]   value;
        logic [DIGIT_W-1:0]   digit;
        logic                 bad;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    ch;
        logic [FIELD_W-1:0]   value;
        logic                 err;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic                 bad;
        logic [DIGIT_W-1:0]   digit;
    } class_t;

    function automatic class_t digit_of(input logic [CHAR_W-1:0] c);
        class_t r;
        r.bad   = 1'b0;
        r.digit = '0;
        if (c >= CH_0 && c <= CH_9)
        begin
            r.digit = DIGIT_W'(c - CH_0);
        end
        else if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r.digit = DIGIT_W'(c - CH_LOW_A + 8'd10);
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r.digit = DIGIT_W'(c - CH_UP_A + 8'd36);
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 6'd10)
        begin
            r = CH_0 + CHAR_W'(d);
        end
        else if (d < 6'd36)
        begin
            r = CH_LOW_A + CHAR_W'(d - 6'd10);
        end
        else
        begin
            r = CH_UP_A + CHAR_W'(d - 6'd36);
        end
        return r;
    endfunction

endpackage

// File: hdl/b62c_fifo.sv
// b62c_fifo: small register queue carrying commands or result items
// depends on nothing; used twice by base62_codec_unit
`timescale 1ns / 1ps

module b62c_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/b62c_front.sv
// b62c_front: direction register, input acceptance and character classification
// depends on b62c_pkg; feeds the command queue
`timescale 1ns / 1ps

module b62c_front #(
    parameter int VALUE_WIDTH = b62c_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         push,
    input  logic [b62c_pkg::FIELD_W-1:0] value_in,
    input  logic [b62c_pkg::CHAR_W-1:0]  char_in,
    input  logic                         last_in,
    input  logic                         cmd_full,
    output logic                         cmd_push,
    output b62c_pkg::cmd_t               cmd
);

    import b62c_pkg::*;

    logic   direction_reg;
    class_t cls;

    assign cfg_ready = 1'b1;
    assign cmd_push  = push && !cmd_full;
    assign cls       = digit_of(char_in);

    always_comb
    begin
        cmd.dec   = direction_reg;
        cmd.value = FIELD_W'(value_in[VALUE_WIDTH-1:0]);
        cmd.digit = cls.digit;
        cmd.bad   = cls.bad;
        cmd.last  = last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            direction_reg <= cfg_data;
        end
    end

endmodule

// File: hdl/b62c_back.sv
// b62c_back: decode accumulator, divide-by-62 digit unit and digit emitter
// depends on b62c_pkg; reads the command queue, writes the result queue
`timescale 1ns / 1ps

module b62c_back #(
    parameter int VALUE_WIDTH = b62c_pkg::VALUE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  b62c_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output b62c_pkg::res_t res
);

    import b62c_pkg::*;

    localparam int CHUNKS = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int DIV_W  = CHUNKS * CHUNK_W;
    localparam int STEP_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   bad_reg, bad_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DIV_W-1:0]       work_reg, work_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [DIGIT_W-1:0]     dig_buf_reg [MAX_DIGITS];
    logic                   dig_wr;

    logic [STEP_X_W-1:0]    step_x;
    logic [PROD_W-1:0]      prod;
    logic [CHUNK_W-1:0]     quo;
    logic [STEP_X_W-1:0]    step_diff;
    logic [DIGIT_W-1:0]     rem_new;
    logic [DIV_W-1:0]       work_shift;
    logic [VALUE_WIDTH-1:0] acc_mac;
    logic [VALUE_WIDTH-1:0] acc_upd;
    logic                   bad_upd;

    // one chunk of long division by 62
    assign step_x     = {rem_reg, work_reg[DIV_W-1 -: CHUNK_W]};
    assign prod       = PROD_W'(step_x) * PROD_W'(RECIP_62);
    assign quo        = prod[RECIP_SHIFT +: CHUNK_W];
    assign step_diff  = step_x - (STEP_X_W'({quo, 6'b0}) - STEP_X_W'({quo, 1'b0}));
    assign rem_new    = step_diff[DIGIT_W-1:0];
    assign work_shift = (work_reg << CHUNK_W) | DIV_W'(quo);

    // acc * 62 + digit
    assign acc_mac = (acc_reg << 6) - (acc_reg << 1) + VALUE_WIDTH'(cmd.digit);
    assign bad_upd = bad_reg | cmd.bad;
    assign acc_upd = cmd.bad ? acc_reg : acc_mac;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        dig_wr     = 1'b0;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res.ch     = '0;
        res.value  = '0;
        res.err    = 1'b0;
        res.last   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.dec)
                    begin
                        if (cmd.last)
                        begin
                            res_push  = 1'b1;
                            res.value = bad_upd ? FIELD_W'({VALUE_WIDTH{1'b1}})
                                                : FIELD_W'(acc_upd);
                            res.err   = bad_upd;
                            acc_next  = '0;
                            bad_next  = 1'b0;
                        end
                        else
                        begin
                            acc_next = acc_upd;
                            bad_next = bad_upd;
                        end
                    end
                    else
                    begin
                        work_next  = DIV_W'(cmd.value[VALUE_WIDTH-1:0]);
                        rem_next   = '0;
                        step_next  = '0;
                        count_next = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                work_next = work_shift;
                rem_next  = rem_new;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CHUNKS - 1))
                begin
                    dig_wr     = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    step_next  = '0;
                    if (work_shift == '0 || count_reg == CNT_W'(MAX_DIGITS - 1))
                    begin
                        idx_next   = count_reg;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                res.ch   = char_of(dig_buf_reg[idx_reg]);
                res.last = (idx_reg == '0);
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            bad_reg   <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            bad_reg   <= bad_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (dig_wr)
        begin
            dig_buf_reg[count_reg] <= rem_new;
        end
    end

endmodule

// File: hdl/base62_codec_unit.sv
// base62_codec_unit: top level of the base62 encoder / decoder
// depends on b62c_pkg, b62c_front, b62c_fifo and b62c_back
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  input   | push / full               | value_in, char_in, last_in
//  result  | pop / empty               | char_out, value_out, error, last_out
//  config  | cfg_valid / cfg_ready     | cfg_data (direction, 1 = decode)
//
// decode: one character per cycle through the multiply-accumulate while the result queue has room
// encode: the divide-by-62 unit finds each digit by long division over 16-bit chunks,
//   then the digits go out, one per cycle while the result queue has room, before the next value is taken
// reset clears both queues, the accumulator and selects encode
// a two-item command queue and a two-item result queue decouple the stalls
`timescale 1ns / 1ps

module base62_codec_unit #(
    parameter int VALUE_WIDTH = b62c_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [b62c_pkg::FIELD_W-1:0] value_in,
    input  logic [b62c_pkg::CHAR_W-1:0]  char_in,
    input  logic                         last_in,
    input  logic                         pop,
    output logic                         empty,
    output logic [b62c_pkg::CHAR_W-1:0]  char_out,
    output logic [b62c_pkg::FIELD_W-1:0] value_out,
    output logic                         error,
    output logic                         last_out
);

    import b62c_pkg::*;

    cmd_t cmd_wr, cmd_rd;
    res_t res_wr, res_rd;
    logic cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic res_push, res_full;

    b62c_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .value_in  (value_in),
        .char_in   (char_in),
        .last_in   (last_in),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_wr)
    );

    assign full = cmd_full;

    b62c_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    b62c_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_rd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_wr)
    );

    b62c_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign char_out  = res_rd.ch;
    assign value_out = res_rd.value;
    assign error     = res_rd.err;
    assign last_out  = res_rd.last;

endmodule

// File: bench/base62_codec_unit_test.sv
// base62_codec_unit_test: self-checking bench for the base62 encoder / decoder
// drives directed and random items through base62_codec_unit under random idling
// depends on b62c_pkg and base62_codec_unit
`timescale 1ns / 1ps

module base62_codec_unit_test;
    import b62c_pkg::*;

    localparam int   SETTLE_CYCLES = 80;
    localparam int   STALL_LIMIT   = 4000;
    localparam logic DIR_ENCODE    = 1'b0;
    localparam logic DIR_DECODE    = 1'b1;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;
    logic                push;
    logic                full;
    logic [FIELD_W-1:0]  value_in;
    logic [CHAR_W-1:0]   char_in;
    logic                last_in;
    logic                pop;
    logic                empty;
    logic [CHAR_W-1:0]   char_out;
    logic [FIELD_W-1:0]  value_out;
    logic                error;
    logic                last_out;

    res_t                awaited_results[$];
    logic                dir_model;
    logic [FIELD_W-1:0]  acc_model;
    logic                bad_model;
    int                  errors;
    int                  quiet_cycles;
    int                  in_gap_max;
    int                  out_stall_max;

    base62_codec_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .value_in  (value_in),
        .char_in   (char_in),
        .last_in   (last_in),
        .pop       (pop),
        .empty     (empty),
        .char_out  (char_out),
        .value_out (value_out),
        .error     (error),
        .last_out  (last_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [CHAR_W-1:0] glyph_of(input int d);
        if (d < 10)
        begin
            return CH_0 + CHAR_W'(d);
        end
        if (d < 36)
        begin
            return CH_LOW_A + CHAR_W'(d - 10);
        end
        return CH_UP_A + CHAR_W'(d - 36);
    endfunction

    // -1 for a byte outside the alphabet
    function automatic int weight_of(input logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return int'(c - CH_0);
        end
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            return int'(c - CH_LOW_A) + 10;
        end
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            return int'(c - CH_UP_A) + 36;
        end
        return -1;
    endfunction

    function automatic void predict_base62(input logic [FIELD_W-1:0] v,
                                           input logic [CHAR_W-1:0] c,
                                           input logic l);
        logic [DIGIT_W-1:0] digits [0:MAX_DIGITS-1];
        int                 n;
        int                 k;
        int                 w;
        res_t               r;
        if (dir_model == DIR_ENCODE)
        begin
            n = 0;
            do
            begin
                digits[n] = DIGIT_W'(v % 64'd62);
                n++;
                v = v / 64'd62;
            end
            while (v != 0);
            for (k = n - 1; k >= 0; k--)
            begin
                r.ch    = glyph_of(int'(digits[k]));
                r.value = '0;
                r.err   = 1'b0;
                r.last  = (k == 0);
                awaited_results.insert(awaited_results.size(), r);
            end
        end
        else
        begin
            w = weight_of(c);
            if (w < 0)
            begin
                bad_model = 1'b1;
            end
            else
            begin
                acc_model = acc_model * 64'd62 + FIELD_W'(w);
            end
            if (l)
            begin
                r.ch    = '0;
                r.value = bad_model ? '1 : acc_model;
                r.err   = bad_model;
                r.last  = 1'b1;
                awaited_results.insert(awaited_results.size(), r);
                acc_model = '0;
                bad_model = 1'b0;
            end
        end
    endfunction

    task automatic send_item(input logic [FIELD_W-1:0] v, input logic [CHAR_W-1:0] c,
                             input logic l);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push     <= 1'b1;
        value_in <= v;
        char_in  <= c;
        last_in  <= l;
        do @(posedge clk); while (full);
        predict_base62(v, c, l);
    endtask

    task automatic release_input();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        release_input();
        while (awaited_results.size() != 0) @(negedge clk);
        // a string without its last character gives no result but may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_direction(input logic d);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        dir_model = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic encode_value(input logic [FIELD_W-1:0] v);
        send_item(v, CHAR_W'($urandom), 1'($urandom));
    endtask

    task automatic decode_char(input logic [CHAR_W-1:0] c, input logic l);
        send_item({$urandom, $urandom}, c, l);
    endtask

    task automatic decode_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            decode_char(CHAR_W'(s[i]), i == s.len() - 1);
        end
    endtask

    function automatic logic [CHAR_W-1:0] stray_byte();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom); while (weight_of(c) >= 0);
        return c;
    endfunction

    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] v;
        logic [FIELD_W-1:0] p;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;
            1: v = v >> $urandom_range(0, 63);
            2:
            begin
                // around a power of 62, where the digit count steps
                p = 64'd1;
                repeat ($urandom_range(0, 10)) p = p * 64'd62;
                v = p + FIELD_W'($urandom_range(0, 2)) - 64'd1;
            end
            default: v = FIELD_W'($urandom_range(0, 61));
        endcase
        return v;
    endfunction

    task automatic test_encode_directed();
        logic [FIELD_W-1:0] vals [8];
        vals = '{64'd0, 64'd1, 64'd61, 64'd62, 64'd839299365868340223,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA};
        in_gap_max    = 3;
        out_stall_max = 3;
        write_direction(DIR_ENCODE);
        foreach (vals[i])
        begin
            encode_value(vals[i]);
        end
    endtask

    task automatic test_decode_directed();
        logic [CHAR_W-1:0] bad_bytes [8];
        bad_bytes = '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF};
        write_direction(DIR_DECODE);
        decode_text("0");
        decode_text("9zZ");
        foreach (bad_bytes[i])
        begin
            decode_char(bad_bytes[i], i == 7);
        end
    endtask

    task automatic test_direction_switch();
        decode_char("a", 1'b0);
        decode_char("b", 1'b0);
        write_direction(DIR_ENCODE);
        encode_value(random_operand());
        encode_value(random_operand());
        write_direction(DIR_DECODE);
        decode_char("c", 1'b1);
    endtask

    task automatic run_encode(input int count);
        repeat (count) encode_value(random_operand());
    endtask

    task automatic run_decode(input int count);
        int                sent;
        int                len;
        int                bad_at;
        int                i;
        logic [CHAR_W-1:0] c;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                decode_char(CHAR_W'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                // long strings wrap the accumulator
                len    = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 14)
                                                     : $urandom_range(1, 10);
                bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
                for (i = 0; i < len; i++)
                begin
                    c = (i == bad_at) ? stray_byte() : glyph_of($urandom_range(0, 61));
                    decode_char(c, i == len - 1);
                end
                sent += len;
            end
        end
    endtask

    task automatic test_random_traffic();
        in_gap_max    = 3;
        out_stall_max = 3;
        write_direction(DIR_ENCODE);
        run_encode(75);
        write_direction(DIR_DECODE);
        run_decode(85);
    endtask

    task automatic test_steady_flow();
        in_gap_max    = 0;
        out_stall_max = 0;
        write_direction(DIR_ENCODE);
        run_encode(60);
        write_direction(DIR_DECODE);
        run_decode(60);
    endtask

    task automatic test_backpressure();
        in_gap_max    = 0;
        out_stall_max = 3;
        write_direction(DIR_ENCODE);
        run_encode(30);
        in_gap_max    = 3;
        out_stall_max = 0;
        write_direction(DIR_DECODE);
        run_decode(30);
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    initial
    begin : result_checker
        int   stall;
        res_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            @(negedge clk);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: expected no item got char %h value %h error %b last %b",
                         $time, char_out, value_out, error, last_out);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("char_out", FIELD_W'(want.ch), FIELD_W'(char_out));
                check_field("value_out", want.value, value_out);
                check_field("error", FIELD_W'(want.err), FIELD_W'(error));
                check_field("last_out", FIELD_W'(want.last), FIELD_W'(last_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        push          = 1'b0;
        value_in      = '0;
        char_in       = '0;
        last_in       = 1'b0;
        pop           = 1'b0;
        dir_model     = DIR_ENCODE;
        acc_model     = '0;
        bad_model     = 1'b0;
        errors        = 0;
        quiet_cycles  = 0;
        in_gap_max    = 3;
        out_stall_max = 3;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_encode_directed();
        test_decode_directed();
        test_direction_switch();
        test_random_traffic();
        test_steady_flow();
        test_backpressure();

        wait_drained();
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
